### rtl/pbc_pkg.sv
// power button controller package: codes, configuration and state types
// shared by pbc_cfg, pbc_core and power_button_controller_top; no dependencies
package pbc_pkg;

  localparam int FuncW    = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int TimeW    = 16;
  localparam int PollW    = 15;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK        = 3'd0,
    FUNC_EDGE        = 3'd1,
    FUNC_TURN_ON     = 3'd2,
    FUNC_DELAYED_OFF = 3'd3,
    FUNC_FORCE_OFF   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    DEV_OFF     = 2'd0,
    DEV_ON      = 2'd1,
    DEV_INIT    = 2'd2,
    DEV_DELAYED = 2'd3
  } dev_e;

  typedef enum logic [2:0] {
    ARM_OFF_VALID    = 3'd0,
    ARM_OFF_INVALID  = 3'd1,
    ARM_NA           = 3'd2,
    ARM_OFF_POSSIBLE = 3'd3,
    ARM_ON_POSSIBLE  = 3'd4
  } arm_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TURN_ON   = 3'd0,
    CFG_SHUTDOWN  = 3'd1,
    CFG_FORCE_OFF = 3'd2,
    CFG_POLL      = 3'd3,
    CFG_DEBOUNCE  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0] turn_on_ms;
    logic [TimeW-1:0] shutdown_ms;
    logic [TimeW-1:0] force_off_ms;
    logic [PollW-1:0] poll_interval_ms;
    logic [TimeW-1:0] debounce_ms;
  } cfg_t;

  // controller state apart from the press and release counters
  typedef struct packed {
    arm_e             arm;
    dev_e             dev;
    logic [TimeW-1:0] off_cnt;
    logic [TimeW-1:0] next_query;
    logic             switch_idle;
    logic             warning;
    logic             power_on;
  } ctl_t;

  typedef struct packed {
    logic       power_enable;
    logic       red_led;
    logic [1:0] device_mode;
    logic [2:0] arm_mode;
    logic       shutdown_warning;
    logic       wake_pulse;
    logic       query_pulse;
    logic       device_active;
  } result_t;

  localparam logic [TimeW-1:0] TurnOnReset   = 16'd10;
  localparam logic [TimeW-1:0] ShutdownReset = 16'd2000;
  localparam logic [TimeW-1:0] ForceOffReset = 16'd3000;
  localparam logic [PollW-1:0] PollReset     = 15'd1000;
  localparam logic [TimeW-1:0] DebounceReset = 16'd200;

  localparam ctl_t CtlReset = '{
    arm:         ARM_ON_POSSIBLE,
    dev:         DEV_OFF,
    off_cnt:     '0,
    next_query:  ShutdownReset,
    switch_idle: 1'b1,
    warning:     1'b0,
    power_on:    1'b0
  };

endpackage

### rtl/pbc_cfg.sv
// power button controller configuration registers with write decode
// depends on pbc_pkg
module pbc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pbc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pbc_pkg::CfgDataW-1:0] cfg_data_i,
  output pbc_pkg::cfg_t                cfg_o
);
  import pbc_pkg::*;

  cfg_t cfg_d, cfg_q;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  // write decode, indexes beyond the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TURN_ON:   cfg_d.turn_on_ms       = cfg_data_i;
        CFG_SHUTDOWN:  cfg_d.shutdown_ms      = cfg_data_i;
        CFG_FORCE_OFF: cfg_d.force_off_ms     = cfg_data_i;
        CFG_POLL:      cfg_d.poll_interval_ms = cfg_data_i[PollW-1:0];
        CFG_DEBOUNCE:  cfg_d.debounce_ms      = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{
        turn_on_ms:       TurnOnReset,
        shutdown_ms:      ShutdownReset,
        force_off_ms:     ForceOffReset,
        poll_interval_ms: PollReset,
        debounce_ms:      DebounceReset
      };
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/pbc_core.sv
// power button controller step logic: next state and result for one item
// purely combinational; depends on pbc_pkg
module pbc_core #(
  parameter int COUNT_BITS = 16
) (
  input  pbc_pkg::cfg_t                cfg_i,
  input  pbc_pkg::ctl_t                ctl_i,
  input  logic [COUNT_BITS-1:0]        press_i,
  input  logic [COUNT_BITS-1:0]        release_i,
  input  logic [pbc_pkg::FuncW-1:0]    func_i,
  input  logic                         down_i,
  output pbc_pkg::ctl_t                ctl_o,
  output logic [COUNT_BITS-1:0]        press_o,
  output logic [COUNT_BITS-1:0]        release_o,
  output pbc_pkg::result_t             result_o
);
  import pbc_pkg::*;

  // compare width covers both the counters and the 16 bit times
  localparam int CW = (COUNT_BITS > TimeW) ? COUNT_BITS : TimeW;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic ctl_t power_off(input ctl_t s);
    ctl_t t;
    t = s;
    if (t.arm == ARM_OFF_INVALID) t.arm = ARM_OFF_VALID;
    t.power_on = 1'b0;
    t.dev      = DEV_OFF;
    t.warning  = 1'b0;
    t.off_cnt  = '0;
    return t;
  endfunction

  ctl_t                  c;
  logic [COUNT_BITS-1:0] p;
  logic [COUNT_BITS-1:0] r;
  logic                  wake;
  logic                  query;
  logic [TimeW:0]        nq_sum;

  always_comb begin
    c      = ctl_i;
    p      = press_i;
    r      = release_i;
    wake   = 1'b0;
    query  = 1'b0;
    nq_sum = '0;
    unique case (func_e'(func_i))
      FUNC_TICK: begin
        // press and release counters
        if (down_i) begin
          p = sat_inc(p);
          r = '0;
        end else begin
          r = sat_inc(r);
        end
        // press handling by arming state
        if (CW'(p) == CW'(cfg_i.turn_on_ms) && c.arm == ARM_ON_POSSIBLE) begin
          c.dev     = DEV_INIT;
          c.warning = 1'b0;
          p         = sat_inc(p);
        end else if (c.arm == ARM_OFF_POSSIBLE) begin
          if (CW'(p) == CW'(cfg_i.turn_on_ms)) begin
            wake = 1'b1;
            p    = sat_inc(p);
          end else if (CW'(p) > CW'(cfg_i.force_off_ms)) begin
            c.arm = ARM_OFF_INVALID;
            c     = power_off(c);
          end else if (CW'(p) > CW'(cfg_i.shutdown_ms)) begin
            c.warning = 1'b1;
            if (CW'(p) > CW'(c.next_query)) begin
              query        = 1'b1;
              nq_sum       = {1'b0, c.next_query} + (TimeW+1)'(cfg_i.poll_interval_ms);
              c.next_query = nq_sum[TimeW] ? '1 : nq_sum[TimeW-1:0];
            end
          end else begin
            c.next_query = cfg_i.shutdown_ms;
          end
        end
        // debounced release re-arms
        if (CW'(r) > CW'(cfg_i.debounce_ms)) begin
          p = '0;
          if (c.dev == DEV_ON) c.arm = ARM_OFF_POSSIBLE;
          else if (c.dev == DEV_OFF) c.arm = ARM_ON_POSSIBLE;
          c.switch_idle = 1'b1;
        end else begin
          c.switch_idle = 1'b0;
        end
        // delayed off countdown
        if (c.off_cnt != '0) begin
          c.off_cnt = c.off_cnt - 1'b1;
          c.warning = 1'b1;
          if (c.off_cnt == TimeW'(cfg_i.poll_interval_ms)) query = 1'b1;
          else if (c.off_cnt == '0) c = power_off(c);
        end
      end
      FUNC_EDGE: begin
        c.switch_idle = 1'b0;
        if (down_i) p = '0;
        else r = '0;
      end
      FUNC_TURN_ON: begin
        c.off_cnt  = '0;
        c.warning  = 1'b0;
        c.power_on = 1'b1;
        c.dev      = DEV_ON;
        c.arm      = ARM_NA;
      end
      FUNC_DELAYED_OFF: begin
        if (c.dev != DEV_DELAYED && c.dev != DEV_OFF) begin
          c.dev     = DEV_DELAYED;
          query     = 1'b1;
          c.off_cnt = {cfg_i.poll_interval_ms, 1'b0};
          c.warning = 1'b1;
        end
      end
      FUNC_FORCE_OFF: begin
        c = power_off(c);
      end
      default: begin
        c = ctl_i;
      end
    endcase
  end

  assign ctl_o     = c;
  assign press_o   = p;
  assign release_o = r;

  // result fields sampled after the step
  always_comb begin
    result_o.power_enable     = c.power_on;
    result_o.red_led          = ~c.power_on;
    result_o.device_mode      = c.dev;
    result_o.arm_mode         = c.arm;
    result_o.shutdown_warning = c.warning;
    result_o.wake_pulse       = wake;
    result_o.query_pulse      = query;
    result_o.device_active    = ~(c.switch_idle && c.dev == DEV_OFF);
  end

endmodule

### rtl/power_button_controller_top.sv
// power button controller top level: input register, state, result register
// depends on pbc_pkg, pbc_cfg and pbc_core
//
// Usage: each input transfer carries one millisecond tick (with the sampled
// button level) or one event: button edge, turn on, delayed off, force off.
// Every input transfer gives exactly one result transfer with the power
// enable, red lamp, device and arming modes, warning level and the wake and
// query pulses. Configuration registers are written over the cfg channel
// (index 0 turn-on time, 1 shutdown time, 2 force-off time, 3 poll interval,
// 4 debounce time) while no item is in flight; cfg_ready_o is always high.
// Path: each item waits in the input register, then the step logic writes its
// result into the result register, from which its result transfer is made.
// Throughput: one item per cycle while out_ready_i stays high; the step logic
// updates all state combinationally, so the next item uses it directly.
// Reset: registers take their default times, counters clear, the device is
// off and armed for power up; both pipeline registers empty.
// Stall: while out_ready_i is low the result holds, the input register keeps
// one more item, and in_ready_o drops once both are full.
module power_button_controller_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pbc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pbc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pbc_pkg::FuncW-1:0]    func_i,
  input  logic                         button_down_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         power_enable_o,
  output logic                         red_led_o,
  output logic [1:0]                   device_mode_o,
  output logic [2:0]                   arm_mode_o,
  output logic                         shutdown_warning_o,
  output logic                         wake_pulse_o,
  output logic                         query_pulse_o,
  output logic                         device_active_o
);
  import pbc_pkg::*;

  cfg_t                  cfg;
  logic                  s1_valid_q, s1_valid_d;
  logic [FuncW-1:0]      s1_func_q;
  logic                  s1_down_q;
  logic                  advance;
  logic                  out_valid_q, out_valid_d;
  result_t               result_q, result_d;
  ctl_t                  ctl_q, ctl_d;
  logic [COUNT_BITS-1:0] press_q, press_d;
  logic [COUNT_BITS-1:0] release_q, release_d;

  // configuration registers
  pbc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // step logic
  pbc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .cfg_i     (cfg),
    .ctl_i     (ctl_q),
    .press_i   (press_q),
    .release_i (release_q),
    .func_i    (s1_func_q),
    .down_i    (s1_down_q),
    .ctl_o     (ctl_d),
    .press_o   (press_d),
    .release_o (release_d),
    .result_o  (result_d)
  );

  // pipeline flow control
  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign s1_valid_d  = (in_valid_i && in_ready_o) || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctl_q       <= CtlReset;
      press_q     <= '0;
      release_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        ctl_q     <= ctl_d;
        press_q   <= press_d;
        release_q <= release_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_func_q <= func_i;
      s1_down_q <= button_down_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign power_enable_o     = result_q.power_enable;
  assign red_led_o          = result_q.red_led;
  assign device_mode_o      = result_q.device_mode;
  assign arm_mode_o         = result_q.arm_mode;
  assign shutdown_warning_o = result_q.shutdown_warning;
  assign wake_pulse_o       = result_q.wake_pulse;
  assign query_pulse_o      = result_q.query_pulse;
  assign device_active_o    = result_q.device_active;

`ifndef SYNTHESIS
  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output register");

  // a stalled result keeps the waiting item in the input register
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q)
    else $error("waiting item lost during output stall");

  // power is never on while the device is off
  a_power_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.power_on |-> ctl_q.dev != DEV_OFF)
    else $error("power enabled with device off");
`endif

endmodule

### bench/tb_top.sv
// testbench for power_button_controller_top: directed and random ticks and events,
// checked in order against a cycle-free model of the controller kept in this file
// depends on pbc_pkg and the rtl under rtl/
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pbc_pkg::*;

  localparam logic [FuncW-1:0]   FuncUnusedFirst = 3'd5;
  localparam logic [FuncW-1:0]   FuncUnusedLast  = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgUnused       = 3'd7;
  localparam logic [TimeW-1:0]   CountMax        = '1;
  localparam int                 SatTicks        = 30;
  localparam int                 PhaseItems      = 180;
  localparam int                 MaxReports      = 40;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [FuncW-1:0]    func_i        = '0;
  logic                button_down_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic                power_enable_o;
  logic                red_led_o;
  logic [1:0]          device_mode_o;
  logic [2:0]          arm_mode_o;
  logic                shutdown_warning_o;
  logic                wake_pulse_o;
  logic                query_pulse_o;
  logic                device_active_o;

  // controller model: registers, state and the results still owed
  cfg_t             cfg_model;
  ctl_t             ctl_model;
  logic [TimeW-1:0] press_ms;
  logic [TimeW-1:0] release_ms;
  result_t          expected_results[$];

  int          mismatches     = 0;
  int unsigned items_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_hold      = 0;

  power_button_controller_top i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // saturating millisecond counter
  function automatic logic [TimeW-1:0] sat_bump(logic [TimeW-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  function automatic void power_down();
    if (ctl_model.arm == ARM_OFF_INVALID) ctl_model.arm = ARM_OFF_VALID;
    ctl_model.power_on = 1'b0;
    ctl_model.dev      = DEV_OFF;
    ctl_model.warning  = 1'b0;
    ctl_model.off_cnt  = '0;
  endfunction

  // one tick or event applied to the model, returns the result it owes
  function automatic result_t step_controller(logic [FuncW-1:0] f, logic down);
    logic           wake;
    logic           query;
    logic [TimeW:0] sum;
    result_t        r;
    wake  = 1'b0;
    query = 1'b0;
    case (f)
      FUNC_TICK: begin
        if (down) begin
          press_ms   = sat_bump(press_ms);
          release_ms = '0;
        end else begin
          release_ms = sat_bump(release_ms);
        end
        // press handling depends on the arming state
        if (press_ms == cfg_model.turn_on_ms && ctl_model.arm == ARM_ON_POSSIBLE) begin
          ctl_model.dev     = DEV_INIT;
          ctl_model.warning = 1'b0;
          press_ms          = sat_bump(press_ms);
        end else if (ctl_model.arm == ARM_OFF_POSSIBLE) begin
          if (press_ms == cfg_model.turn_on_ms) begin
            wake     = 1'b1;
            press_ms = sat_bump(press_ms);
          end else if (press_ms > cfg_model.force_off_ms) begin
            ctl_model.arm = ARM_OFF_INVALID;
            power_down();
          end else if (press_ms > cfg_model.shutdown_ms) begin
            ctl_model.warning = 1'b1;
            if (press_ms > ctl_model.next_query) begin
              query = 1'b1;
              sum   = ctl_model.next_query + cfg_model.poll_interval_ms;
              ctl_model.next_query = sum[TimeW] ? CountMax : sum[TimeW-1:0];
            end
          end else begin
            ctl_model.next_query = cfg_model.shutdown_ms;
          end
        end
        // debounced release re-arms
        if (release_ms > cfg_model.debounce_ms) begin
          press_ms = '0;
          if (ctl_model.dev == DEV_ON && ctl_model.arm != ARM_OFF_POSSIBLE) begin
            ctl_model.arm = ARM_OFF_POSSIBLE;
          end else if (ctl_model.dev == DEV_OFF && ctl_model.arm != ARM_ON_POSSIBLE) begin
            ctl_model.arm = ARM_ON_POSSIBLE;
          end
          ctl_model.switch_idle = 1'b1;
        end else begin
          ctl_model.switch_idle = 1'b0;
        end
        // delayed-off countdown
        if (ctl_model.off_cnt != '0) begin
          ctl_model.off_cnt = ctl_model.off_cnt - 1'b1;
          ctl_model.warning = 1'b1;
          if (ctl_model.off_cnt == cfg_model.poll_interval_ms) query = 1'b1;
          else if (ctl_model.off_cnt == '0) power_down();
        end
      end
      FUNC_EDGE: begin
        ctl_model.switch_idle = 1'b0;
        if (down) press_ms = '0;
        else release_ms = '0;
      end
      FUNC_TURN_ON: begin
        ctl_model.off_cnt  = '0;
        ctl_model.warning  = 1'b0;
        ctl_model.power_on = 1'b1;
        ctl_model.dev      = DEV_ON;
        ctl_model.arm      = ARM_NA;
      end
      FUNC_DELAYED_OFF: begin
        if (ctl_model.dev != DEV_DELAYED && ctl_model.dev != DEV_OFF) begin
          ctl_model.dev     = DEV_DELAYED;
          query             = 1'b1;
          ctl_model.off_cnt = {cfg_model.poll_interval_ms, 1'b0};
          ctl_model.warning = 1'b1;
        end
      end
      FUNC_FORCE_OFF: power_down();
      default: ;
    endcase
    r.power_enable     = ctl_model.power_on;
    r.red_led          = ~ctl_model.power_on;
    r.device_mode      = ctl_model.dev;
    r.arm_mode         = ctl_model.arm;
    r.shutdown_warning = ctl_model.warning;
    r.wake_pulse       = wake;
    r.query_pulse      = query;
    r.device_active    = !(ctl_model.switch_idle && ctl_model.dev == DEV_OFF);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
    end
  endfunction

  // result check and prediction of every input transfer
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {power_enable_o, red_led_o, device_mode_o, arm_mode_o,
               shutdown_warning_o, wake_pulse_o, query_pulse_o, device_active_o};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("%0t ns: result expected none, got %b", $time, got);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("power_enable", want.power_enable, got.power_enable);
          check_field("red_led", want.red_led, got.red_led);
          check_field("device_mode", want.device_mode, got.device_mode);
          check_field("arm_mode", want.arm_mode, got.arm_mode);
          check_field("shutdown_warning", want.shutdown_warning, got.shutdown_warning);
          check_field("wake_pulse", want.wake_pulse, got.wake_pulse);
          check_field("query_pulse", want.query_pulse, got.query_pulse);
          check_field("device_active", want.device_active, got.device_active);
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(step_controller(func_i, button_down_i));
      end
    end
  end

  // result side: long hold-off when asked, random stalls otherwise
  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      out_ready_i <= 1'b0;
      recv_hold--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(logic [FuncW-1:0] f, logic down);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    button_down_i <= down;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic ticks(logic down, int unsigned n);
    repeat (n) send_item(FUNC_TICK, down);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TURN_ON:   cfg_model.turn_on_ms       = data;
      CFG_SHUTDOWN:  cfg_model.shutdown_ms      = data;
      CFG_FORCE_OFF: cfg_model.force_off_ms     = data;
      CFG_POLL:      cfg_model.poll_interval_ms = data[PollW-1:0];
      CFG_DEBOUNCE:  cfg_model.debounce_ms      = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(int unsigned on_ms, int unsigned sd_ms, int unsigned fo_ms,
                            int unsigned poll_ms, int unsigned db_ms);
    wait_drained();
    write_reg(CFG_TURN_ON, CfgDataW'(on_ms));
    write_reg(CFG_SHUTDOWN, CfgDataW'(sd_ms));
    write_reg(CFG_FORCE_OFF, CfgDataW'(fo_ms));
    write_reg(CFG_POLL, CfgDataW'(poll_ms));
    write_reg(CFG_DEBOUNCE, CfgDataW'(db_ms));
  endtask

  // reset state seen through unused codes, edges and single ticks
  task automatic test_reset_values();
    for (int f = FuncUnusedFirst; f <= FuncUnusedLast; f++) send_item(FuncW'(f), f[0]);
    send_item(FUNC_EDGE, 1'b1);
    send_item(FUNC_EDGE, 1'b0);
    ticks(1'b0, 1);
    ticks(1'b1, 1);
    send_item(FUNC_FORCE_OFF, 1'b0);
  endtask

  // all registers at their top values, then all at one
  task automatic test_register_extremes();
    set_config(CountMax, CountMax, CountMax, 16'h7fff, CountMax);
    ticks(1'b1, 2);
    wait_drained();
    write_reg(CfgUnused, 16'h0001);
    // upper bit of the poll value is dropped
    write_reg(CFG_POLL, 16'hffff);
    send_item(FUNC_EDGE, 1'b1);
    set_config(1, 1, 1, 1, 1);
    ticks(1'b1, 2);
    ticks(1'b0, 3);
  endtask

  // power up, wake, hold queries, delayed off and forced off on short times
  task automatic test_power_sequences();
    set_config(1, 3, 5, 1, 1);
    send_item(FUNC_DELAYED_OFF, 1'b0);
    send_item(FUNC_TURN_ON, 1'b1);
    ticks(1'b0, 2);
    ticks(1'b1, 3);
    send_item(FUNC_DELAYED_OFF, 1'b0);
    // hold query and countdown query land on the same tick
    ticks(1'b1, 1);
    send_item(FUNC_DELAYED_OFF, 1'b1);
    ticks(1'b1, 3);
    send_item(FUNC_EDGE, 1'b0);
    ticks(1'b0, 2);
    ticks(1'b1, 1);
    send_item(FUNC_DELAYED_OFF, 1'b0);
    send_item(FUNC_FORCE_OFF, 1'b1);
  endtask

  // long holds and releases against wide thresholds and a large poll step
  task automatic test_counter_limits();
    set_config(1, 1, 1, 1, 1);
    send_item(FUNC_TURN_ON, 1'b0);
    ticks(1'b0, 2);
    set_config(CountMax, 2, CountMax, 16'hffff, CountMax);
    ticks(1'b1, SatTicks);
    ticks(1'b0, SatTicks);
    send_item(FUNC_FORCE_OFF, 1'b0);
    set_config(CountMax, 2, CountMax, 16'hffff, 1);
    ticks(1'b0, 2);
    ticks(1'b1, SatTicks);
    send_item(FUNC_FORCE_OFF, 1'b1);
  endtask

  // result side holds off until the input stalls, then the sender waits for all results
  task automatic test_backpressure();
    set_config(3, 10, 20, 4, 5);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(FUNC_TURN_ON, 1'b0);
    recv_hold = 60;
    ticks(1'b1, 30);
    wait_drained();
    recv_stall_pct = 48;
    ticks(1'b0, 10);
    ticks(1'b1, 10);
  endtask

  // press, hold and release sequences with random content under each idling pattern
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned kind;
    int unsigned on_ms, sd_ms, fo_ms, poll_ms, db_ms;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      // ordered thresholds mostly, unordered now and then
      if (phase % 3 == 2) begin
        on_ms = $urandom_range(1, 30);
        sd_ms = $urandom_range(1, 30);
        fo_ms = $urandom_range(1, 30);
        poll_ms = $urandom_range(1, 30);
        db_ms = $urandom_range(1, 30);
      end else begin
        on_ms = $urandom_range(1, 8);
        sd_ms = on_ms + $urandom_range(0, 15);
        fo_ms = sd_ms + $urandom_range(0, 15);
        poll_ms = $urandom_range(1, 8);
        db_ms = $urandom_range(1, 12);
      end
      set_config(on_ms, sd_ms, fo_ms, poll_ms, db_ms);
      start = items_sent;
      while (items_sent - start < PhaseItems) begin
        kind = $urandom_range(99);
        if (kind < 55) begin
          // hold with rare glitches and events, then release
          if ($urandom_range(3) == 0) send_item(FUNC_EDGE, 1'b1);
          repeat ($urandom_range(1, fo_ms + 4)) begin
            if ($urandom_range(99) < 4) begin
              send_item(FuncW'($urandom_range(FUNC_TURN_ON, FUNC_FORCE_OFF)),
                        1'($urandom_range(1)));
            end else begin
              send_item(FUNC_TICK, $urandom_range(99) >= 3);
            end
          end
          if ($urandom_range(3) == 0) send_item(FUNC_EDGE, 1'b0);
          ticks(1'b0, $urandom_range(0, db_ms + 3));
        end else if (kind < 72) begin
          send_item(FUNC_TURN_ON, 1'($urandom_range(1)));
          ticks(1'b0, db_ms + $urandom_range(1, 3));
        end else if (kind < 85) begin
          send_item(FUNC_DELAYED_OFF, 1'($urandom_range(1)));
          ticks(1'($urandom_range(1)), $urandom_range(1, 2 * poll_ms + 3));
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_item(FuncW'($urandom_range(FUNC_TICK, FuncUnusedLast)),
                      1'($urandom_range(1)));
          end
        end
      end
    end
  endtask

  initial begin
    cfg_model  = '{TurnOnReset, ShutdownReset, ForceOffReset, PollReset, DebounceReset};
    ctl_model  = CtlReset;
    press_ms   = '0;
    release_ms = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_register_extremes();
    test_power_sequences();
    test_counter_limits();
    test_backpressure();
    test_random_traffic();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
